// ----- rtl/dual_wheel_incremental_pid_defines.svh -----
// Assertion helpers for the wheel controller; sampled on clk, off while arst_n is low.
`ifndef DUAL_WHEEL_INCREMENTAL_PID_DEFINES_SVH
`define DUAL_WHEEL_INCREMENTAL_PID_DEFINES_SVH

// prop is a full property expression (implications allowed)
`define DWIP_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// cond must never hold
`define DWIP_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/dwip_pkg.sv -----
`timescale 1ns / 1ps

package dwip_pkg;

	localparam int SPEED_WIDTH_DEF = 16;
	localparam int GAIN_W = 16;
	localparam int BAND_W = 16;
	localparam int ACC_W = 32;
	localparam int DUTY_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_SMALL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LARGE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd6;

	localparam logic [BAND_W-1:0] BAND_LOW_RST = 16'd80;
	localparam logic [BAND_W-1:0] BAND_HIGH_RST = 16'd160;

	// duty mapping, Q1.16
	localparam logic signed [ACC_W:0] DUTY_HALF = 33'sd32768;
	localparam logic signed [ACC_W:0] DUTY_HI_EDGE = 33'sd62260;
	localparam logic signed [ACC_W:0] DUTY_LO_EDGE = 33'sd3276;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 17'h10000;
	localparam logic [DUTY_W-1:0] DUTY_ZERO = 17'h00000;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic signed [GAIN_W-1:0] integ_gain_small;
		logic signed [GAIN_W-1:0] integ_gain_mid;
		logic signed [GAIN_W-1:0] integ_gain_large;
		logic [BAND_W-1:0] band_low;
		logic [BAND_W-1:0] band_high;
	} cfg_t;

	typedef struct packed {
		logic accept;   // request taken into stage 1, error history shifts
		logic ld_s2;
		logic ld_s3;
		logic acc_upd;  // stage 3 delta folds into the accumulator
	} ctl_t;

endpackage

// ----- rtl/dwip_lane.sv -----
`timescale 1ns / 1ps

module dwip_lane import dwip_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input ctl_t ctl,
	input cfg_t cfg,
	input logic signed [SPEED_WIDTH-1:0] minuend,
	input logic signed [SPEED_WIDTH-1:0] subtrahend,
	output logic signed [ACC_W-1:0] acc
);

	localparam int EW = SPEED_WIDTH + 1;
	localparam int D1W = SPEED_WIDTH + 2;
	localparam int D2W = SPEED_WIDTH + 3;
	localparam int DW = SPEED_WIDTH + GAIN_W + 3;
	localparam int SUMW = ((DW > ACC_W) ? DW : ACC_W) + 1;
	localparam int CW = (EW > BAND_W) ? EW : BAND_W;
	localparam logic signed [SUMW-1:0] ACC_MAX = SUMW'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [SUMW-1:0] ACC_MIN = SUMW'(-64'sh0000_0000_8000_0000);

	logic signed [EW-1:0] e_d;
	logic [EW-1:0] mag_d;
	logic signed [GAIN_W-1:0] ki_d;
	logic signed [D1W-1:0] d1_d;
	logic signed [D2W-1:0] d2_d;

	logic signed [EW-1:0] err_prev_q, err_prev2_q;

	logic signed [EW-1:0] e_s1;
	logic signed [D1W-1:0] d1_s1;
	logic signed [D2W-1:0] d2_s1;
	logic signed [GAIN_W-1:0] ki_s1;

	logic signed [DW-1:0] prod_p_s2, prod_i_s2, prod_d_s2;
	logic signed [DW-1:0] delta_s3;

	logic signed [SUMW-1:0] sum_d;
	logic signed [ACC_W-1:0] acc_d;
	logic signed [ACC_W-1:0] acc_q;

	always_comb begin
		e_d = EW'(minuend) - EW'(subtrahend);
		mag_d = e_d[EW-1] ? $unsigned(-e_d) : $unsigned(e_d);
		if (CW'(mag_d) < CW'(cfg.band_low)) begin
			ki_d = cfg.integ_gain_small;
		end else if (CW'(mag_d) < CW'(cfg.band_high)) begin
			ki_d = cfg.integ_gain_mid;
		end else begin
			ki_d = cfg.integ_gain_large;
		end
		d1_d = D1W'(e_d) - D1W'(err_prev_q);
		d2_d = D2W'(e_d) - (D2W'(err_prev_q) <<< 1) + D2W'(err_prev2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_prev_q <= '0;
			err_prev2_q <= '0;
		end else if (ctl.accept) begin
			err_prev_q <= e_d;
			err_prev2_q <= err_prev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			e_s1 <= e_d;
			d1_s1 <= d1_d;
			d2_s1 <= d2_d;
			ki_s1 <= ki_d;
		end
		if (ctl.ld_s2) begin
			prod_p_s2 <= DW'(cfg.prop_gain) * DW'(d1_s1);
			prod_i_s2 <= DW'(ki_s1) * DW'(e_s1);
			prod_d_s2 <= DW'(cfg.deriv_gain) * DW'(d2_s1);
		end
		if (ctl.ld_s3) begin
			delta_s3 <= prod_p_s2 + prod_i_s2 + prod_d_s2;
		end
	end

	// saturating accumulate
	always_comb begin
		sum_d = SUMW'(acc_q) + SUMW'(delta_s3);
		if (sum_d > ACC_MAX) begin
			acc_d = ACC_MAX[ACC_W-1:0];
		end else if (sum_d < ACC_MIN) begin
			acc_d = ACC_MIN[ACC_W-1:0];
		end else begin
			acc_d = sum_d[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_upd) begin
			acc_q <= acc_d;
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/dwip_merge.sv -----
`timescale 1ns / 1ps

module dwip_merge import dwip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic signed [ACC_W-1:0] acc_left,
	input logic signed [ACC_W-1:0] acc_right,
	input logic stall,
	output logic rdy,
	output logic valid,
	output logic [DUTY_W-1:0] duty_left,
	output logic [DUTY_W-1:0] duty_right
);

	logic valid_q;
	logic [DUTY_W-1:0] duty_left_q, duty_right_q;

	function automatic logic [DUTY_W-1:0] duty_map(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] d;
		logic [DUTY_W-1:0] r;
		d = (ACC_W+1)'(a) + DUTY_HALF;
		if (d >= DUTY_HI_EDGE) begin
			r = DUTY_FULL;
		end else if (d <= DUTY_LO_EDGE) begin
			r = DUTY_ZERO;
		end else begin
			r = d[DUTY_W-1:0];
		end
		return r;
	endfunction

	assign rdy = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy) begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && take) begin
			duty_left_q <= duty_map(acc_left);
			duty_right_q <= duty_map(acc_right);
		end
	end

	assign valid = valid_q;
	assign duty_left = duty_left_q;
	assign duty_right = duty_right_q;

endmodule

// ----- rtl/dual_wheel_incremental_pid.sv -----
// Two-wheel velocity-form PID speed controller. Each request carries target and measured
// speed for both wheels (signed Q12.4) and yields one result with a PWM duty per wheel
// (unsigned Q1.16, 65536 = full). Left error is measured minus target, right error is
// target minus measured; the integral gain is chosen from three bands by error magnitude.
// Both wheels run in identical lanes side by side: error and band select, three gain
// products, their sum, then the saturating 32-bit drive accumulator; a merge stage maps
// both accumulators to duties into the output register. One request is taken every cycle
// while in_stall is low; an accepted request passes the error, product, sum, accumulator
// and output registers in that order. The per-wheel error history and the accumulator
// add-and-saturate are the only loops between requests. Gains and band edges are written through
// cfg_we/cfg_index/cfg_data and must only change while idle.
`timescale 1ns / 1ps
`include "dual_wheel_incremental_pid_defines.svh"

module dual_wheel_incremental_pid import dwip_pkg::*; #(
	parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [SPEED_WIDTH-1:0] target_left,
	input logic signed [SPEED_WIDTH-1:0] target_right,
	input logic signed [SPEED_WIDTH-1:0] measured_left,
	input logic signed [SPEED_WIDTH-1:0] measured_right,
	output logic out_valid,
	input logic out_stall,
	output logic [DUTY_W-1:0] duty_left,
	output logic [DUTY_W-1:0] duty_right
);

	cfg_t cfg_q;
	ctl_t ctl;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;
	logic signed [ACC_W-1:0] acc_left, acc_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= '0;
			cfg_q.deriv_gain <= '0;
			cfg_q.integ_gain_small <= '0;
			cfg_q.integ_gain_mid <= '0;
			cfg_q.integ_gain_large <= '0;
			cfg_q.band_low <= BAND_LOW_RST;
			cfg_q.band_high <= BAND_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN: cfg_q.prop_gain <= signed'(cfg_data);
				REG_DERIV_GAIN: cfg_q.deriv_gain <= signed'(cfg_data);
				REG_INTEG_SMALL: cfg_q.integ_gain_small <= signed'(cfg_data);
				REG_INTEG_MID: cfg_q.integ_gain_mid <= signed'(cfg_data);
				REG_INTEG_LARGE: cfg_q.integ_gain_large <= signed'(cfg_data);
				REG_BAND_LOW: cfg_q.band_low <= cfg_data;
				REG_BAND_HIGH: cfg_q.band_high <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes new data when empty or when it drains this cycle
	assign rdy4 = !valid_s4 || rdy_out;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_comb begin
		ctl.accept = in_valid && rdy1;
		ctl.ld_s2 = rdy2;
		ctl.ld_s3 = rdy3;
		ctl.acc_upd = valid_s3 && rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	dwip_lane #(
		.SPEED_WIDTH(SPEED_WIDTH)
	) u_lane_left (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.cfg(cfg_q),
		.minuend(measured_left),
		.subtrahend(target_left),
		.acc(acc_left)
	);

	dwip_lane #(
		.SPEED_WIDTH(SPEED_WIDTH)
	) u_lane_right (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.cfg(cfg_q),
		.minuend(target_right),
		.subtrahend(measured_right),
		.acc(acc_right)
	);

	dwip_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.take(valid_s4),
		.acc_left(acc_left),
		.acc_right(acc_right),
		.stall(out_stall),
		.rdy(rdy_out),
		.valid(out_valid),
		.duty_left(duty_left),
		.duty_right(duty_right)
	);

	`DWIP_CHECK(a_acc_hold, !ctl.acc_upd |=> ($stable(acc_left) && $stable(acc_right)), "accumulator moved without an update")
	`DWIP_CHECK(a_result_out, (valid_s4 && rdy_out) |=> out_valid, "accumulated request did not reach the output")
	`DWIP_CHECK(a_accept_s1, (in_valid && !in_stall) |=> valid_s1, "accepted request missing from stage 1")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import dwip_pkg::*;

	localparam int SPD_W = SPEED_WIDTH_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic signed [SPD_W-1:0] SPD_MIN = 16'sh8000;
	localparam logic signed [SPD_W-1:0] SPD_MAX = 16'sh7FFF;
	localparam logic [DUTY_W-1:0] DUTY_MID = 17'd32768;
	localparam longint ACC_TOP = 64'sd2147483647;
	localparam longint ACC_BOTTOM = -64'sd2147483648;
	localparam int PHASES = 8;
	localparam int PER_PHASE = 200;

	typedef enum logic [1:0] {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		logic signed [SPD_W-1:0] tl, tr, ml, mr;
		bit fixed;
		logic [DUTY_W-1:0] want_l, want_r;
	} plan_row_t;

	typedef struct {
		logic [DUTY_W-1:0] duty_l;
		logic [DUTY_W-1:0] duty_r;
	} duty_pair_t;

	typedef struct {
		longint err1;
		longint err2;
		longint acc;
	} wheel_hist_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SPD_W-1:0] target_left = '0;
	logic signed [SPD_W-1:0] target_right = '0;
	logic signed [SPD_W-1:0] measured_left = '0;
	logic signed [SPD_W-1:0] measured_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DUTY_W-1:0] duty_left;
	logic [DUTY_W-1:0] duty_right;

	bit steady = 1'b0;
	int mismatches = 0;
	cfg_t pid_cfg;
	wheel_hist_t wheel [2];
	duty_pair_t duty_due [$];

	// sign of the left error is flipped: that wheel turns the other way
	plan_row_t plan [35] = '{
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, DUTY_MID, DUTY_MID},
		'{ROW_REQ, '0, '0, SPD_MIN, SPD_MAX, SPD_MAX, SPD_MIN, 1'b1, DUTY_MID, DUTY_MID},
		'{ROW_REQ, '0, '0, SPD_MAX, SPD_MIN, SPD_MIN, SPD_MAX, 1'b1, DUTY_MID, DUTY_MID},
		'{ROW_REQ, '0, '0, SPD_MIN, SPD_MIN, SPD_MIN, SPD_MIN, 1'b1, DUTY_MID, DUTY_MID},
		'{ROW_REQ, '0, '0, SPD_MAX, SPD_MAX, SPD_MAX, SPD_MAX, 1'b1, DUTY_MID, DUTY_MID},
		'{ROW_REQ, '0, '0, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 1'b1,
			DUTY_MID, DUTY_MID},
		// drive steps by the error itself: walk the duty clamp edges
		'{ROW_CFG, REG_INTEG_SMALL, 16'h0001, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_BAND_LOW, 16'hFFFF, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_UNUSED, 16'hFFFF, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd29492, 16'sd29491, 16'sd0, 1'b1,
			17'd62259, DUTY_FULL},
		'{ROW_REQ, '0, '0, 16'sd26215, SPD_MIN, SPD_MIN, 16'sd26215, 1'b1,
			DUTY_ZERO, 17'd3277},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd29491, 16'sd29492, 16'sd0, 1'b1, DUTY_MID, DUTY_MID},
		// full-scale gains: accumulator saturation both ways, band edges
		'{ROW_CFG, REG_PROP_GAIN, 16'h7FFF, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_DERIV_GAIN, 16'h0000, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_INTEG_SMALL, 16'h8000, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_INTEG_MID, 16'h04D2, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_INTEG_LARGE, 16'h7FFF, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_BAND_LOW, 16'h0050, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_BAND_HIGH, 16'h00A0, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, SPD_MIN, SPD_MAX, SPD_MAX, SPD_MIN, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, SPD_MAX, SPD_MIN, SPD_MIN, SPD_MAX, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, SPD_MIN, SPD_MAX, SPD_MAX, SPD_MIN, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd80, 16'sd79, 16'sd0, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd160, 16'sd159, 16'sd0, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd0, -16'sd80, 16'sd160, 1'b0, '0, '0},
		// empty small band, derivative at its negative limit
		'{ROW_CFG, REG_BAND_LOW, 16'h0000, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_BAND_HIGH, 16'hFFFF, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_PROP_GAIN, 16'h0001, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_DERIV_GAIN, 16'h8000, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, SPD_MIN, SPD_MIN, SPD_MAX, SPD_MAX, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd1, -16'sd1, 16'sd0, 1'b0, '0, '0},
		// bands out of order: mid band empty
		'{ROW_CFG, REG_BAND_LOW, 16'h0064, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_CFG, REG_BAND_HIGH, 16'h0032, '0, '0, '0, '0, 1'b0, '0, '0},
		'{ROW_REQ, '0, '0, 16'sd0, 16'sd120, 16'sd60, 16'sd0, 1'b0, '0, '0}
	};

	dual_wheel_incremental_pid dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_left(target_left),
		.target_right(target_right),
		.measured_left(measured_left),
		.measured_right(measured_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty_left(duty_left),
		.duty_right(duty_right)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 20);
	endfunction

	always @(negedge clk) begin
		out_stall <= idle_now();
	end

	function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		REG_PROP_GAIN: pid_cfg.prop_gain = data;
		REG_DERIV_GAIN: pid_cfg.deriv_gain = data;
		REG_INTEG_SMALL: pid_cfg.integ_gain_small = data;
		REG_INTEG_MID: pid_cfg.integ_gain_mid = data;
		REG_INTEG_LARGE: pid_cfg.integ_gain_large = data;
		REG_BAND_LOW: pid_cfg.band_low = data;
		REG_BAND_HIGH: pid_cfg.band_high = data;
		default: ;
		endcase
	endfunction

	function automatic logic [DUTY_W-1:0] wheel_duty(input int side, input longint err);
		longint mag, ki, step, level, lo, hi;
		lo = pid_cfg.band_low;
		hi = pid_cfg.band_high;
		mag = (err < 0) ? -err : err;
		if (mag < lo)
			ki = $signed(pid_cfg.integ_gain_small);
		else if (mag < hi)
			ki = $signed(pid_cfg.integ_gain_mid);
		else
			ki = $signed(pid_cfg.integ_gain_large);
		step = $signed(pid_cfg.prop_gain) * (err - wheel[side].err1) + ki * err
			+ $signed(pid_cfg.deriv_gain) * (err - 2 * wheel[side].err1 + wheel[side].err2);
		level = wheel[side].acc + step;
		if (level > ACC_TOP)
			level = ACC_TOP;
		if (level < ACC_BOTTOM)
			level = ACC_BOTTOM;
		wheel[side].acc = level;
		wheel[side].err2 = wheel[side].err1;
		wheel[side].err1 = err;
		level = level + DUTY_HALF;
		if (level >= DUTY_HI_EDGE)
			return DUTY_FULL;
		if (level <= DUTY_LO_EDGE)
			return DUTY_ZERO;
		return level[DUTY_W-1:0];
	endfunction

	function automatic duty_pair_t predict_duties(input logic signed [SPD_W-1:0] tl, tr, ml, mr);
		duty_pair_t p;
		p.duty_l = wheel_duty(0, longint'(ml) - longint'(tl));
		p.duty_r = wheel_duty(1, longint'(tr) - longint'(mr));
		return p;
	endfunction

	task automatic flag_miss(input string what, input logic [DUTY_W-1:0] want, got);
		mismatches++;
		if (mismatches <= 10)
			$display("%t %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin : check_duty
		duty_pair_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (duty_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t unexpected duty result %0d / %0d", $realtime,
						duty_left, duty_right);
			end else begin
				due = duty_due.pop_front();
				if (duty_left !== due.duty_l)
					flag_miss("duty_left", due.duty_l, duty_left);
				if (duty_right !== due.duty_r)
					flag_miss("duty_right", due.duty_r, duty_right);
			end
		end
	end

	task automatic send_speeds(input logic signed [SPD_W-1:0] tl, tr, ml, mr,
			input bit fixed, input logic [DUTY_W-1:0] want_l, want_r);
		duty_pair_t due;
		@(negedge clk);
		if (idle_now()) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		target_left <= tl;
		target_right <= tr;
		measured_left <= ml;
		measured_right <= mr;
		do @(posedge clk); while (in_stall);
		due = predict_duties(tl, tr, ml, mr);
		if (fixed) begin
			due.duty_l = want_l;
			due.duty_r = want_r;
		end
		duty_due.push_back(due);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (duty_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		mirror_write(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_edge();
		case ($urandom_range(0, 3))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return 16'h0000;
		default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 4))
		0, 1: return 16'($urandom_range(0, 512) - 256);
		2: return 16'($urandom_range(0, 8192) - 4096);
		3: return 16'($urandom());
		default: return pick_edge();
		endcase
	endfunction

	task automatic retune(input int phase);
		cfg_t next;
		wait_drained();
		if (phase == 0) begin
			next = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF};
		end else if (phase == 1) begin
			next = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000};
		end else begin
			next.prop_gain = pick_gain();
			next.deriv_gain = pick_gain();
			next.integ_gain_small = pick_gain();
			next.integ_gain_mid = pick_gain();
			next.integ_gain_large = pick_gain();
			next.band_low = 16'($urandom_range(0, 500));
			next.band_high = ($urandom_range(0, 4) == 0) ? 16'($urandom())
				: 16'(next.band_low + $urandom_range(0, 600));
			if ($urandom_range(0, 4) == 0)
				next.band_low = 16'($urandom());
		end
		write_reg(REG_PROP_GAIN, next.prop_gain);
		write_reg(REG_DERIV_GAIN, next.deriv_gain);
		write_reg(REG_INTEG_SMALL, next.integ_gain_small);
		write_reg(REG_INTEG_MID, next.integ_gain_mid);
		write_reg(REG_INTEG_LARGE, next.integ_gain_large);
		write_reg(REG_BAND_LOW, next.band_low);
		write_reg(REG_BAND_HIGH, next.band_high);
		if ($urandom_range(0, 1))
			write_reg(REG_UNUSED, 16'($urandom()));
	endtask

	task automatic send_random();
		int base_l, base_r;
		logic signed [SPD_W-1:0] tl, tr, ml, mr;
		case ($urandom_range(0, 19))
		0, 1, 2: begin
			tl = 16'($urandom());
			tr = 16'($urandom());
			ml = 16'($urandom());
			mr = 16'($urandom());
		end
		3, 4: begin
			tl = pick_edge();
			tr = pick_edge();
			ml = pick_edge();
			mr = pick_edge();
		end
		5: begin
			tl = 16'($urandom());
			tr = 16'($urandom());
			ml = tl;
			mr = tr;
		end
		default: begin
			// wheels tracking their targets with small speed errors
			base_l = int'($urandom_range(0, 20000)) - 10000;
			base_r = int'($urandom_range(0, 20000)) - 10000;
			tl = 16'(base_l);
			tr = 16'(base_r);
			ml = 16'(base_l + int'($urandom_range(0, 640)) - 320);
			mr = 16'(base_r + int'($urandom_range(0, 640)) - 320);
		end
		endcase
		send_speeds(tl, tr, ml, mr, 1'b0, '0, '0);
	endtask

	initial begin
		pid_cfg = '0;
		pid_cfg.band_low = BAND_LOW_RST;
		pid_cfg.band_high = BAND_HIGH_RST;
		wheel[0] = '{0, 0, 0};
		wheel[1] = '{0, 0, 0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_speeds(plan[i].tl, plan[i].tr, plan[i].ml, plan[i].mr,
					plan[i].fixed, plan[i].want_l, plan[i].want_r);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			retune(ph);
			steady = (ph == 3);
			for (int n = 0; n < PER_PHASE; n++) begin
				if ($urandom_range(0, 299) == 0)
					wait_drained();
				send_random();
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && duty_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- dual_wheel_incremental_pid.f -----
+incdir+rtl
rtl/dwip_pkg.sv
rtl/dwip_lane.sv
rtl/dwip_merge.sv
rtl/dual_wheel_incremental_pid.sv
bench/tb.sv
